// File: sv/dks_pkg.sv
// Shared constants, permutation tables and helper functions for the DES key schedule.
package dks_pkg;

	localparam int KEY_W  = 64;
	localparam int CD_W   = 56;
	localparam int HALF_W = 28;
	localparam int RK_W   = 48;
	localparam int ROUNDS = 16;
	localparam int IDX_W  = $clog2(ROUNDS);

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [CD_W-1:0]   cd_t;
	typedef logic [RK_W-1:0]   rkey_t;
	typedef logic [IDX_W-1:0]  ridx_t;

	// A set bit marks a round whose halves rotate by two places instead of one.
	localparam logic [ROUNDS-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

	// Table entry n selects source bit n-1, counted from the least significant bit.
	localparam logic [6:0] PC1_TAB [CD_W] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
		7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
		7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
		7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
		7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
		7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
		7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
	};

	localparam logic [6:0] PC2_TAB [RK_W] = '{
		7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
		7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
		7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
		7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
		7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
		7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
		7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
		7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
	};

	function automatic cd_t pc1(input logic [KEY_W-1:0] key);
		cd_t r;
		r = '0;
		for (int i = 0; i < CD_W; i++) begin
			r[i] = key[6'(PC1_TAB[i] - 7'd1)];
		end
		return r;
	endfunction

	function automatic rkey_t pc2(input cd_t cd);
		rkey_t r;
		r = '0;
		for (int i = 0; i < RK_W; i++) begin
			r[i] = cd[6'(PC2_TAB[i] - 7'd1)];
		end
		return r;
	endfunction

	function automatic half_t rotl(input half_t x, input logic two);
		return two ? {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]} : {x[HALF_W-2:0], x[HALF_W-1]};
	endfunction

endpackage

// File: sv/dks_cell.sv
// One round cell: rotates the halves it receives and holds them for its round.
module dks_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           rot_two,
	input  logic           v_i,
	input  dks_pkg::half_t c_i,
	input  dks_pkg::half_t d_i,
	output logic           v_o,
	output dks_pkg::half_t c_o,
	output dks_pkg::half_t d_o
);
	import dks_pkg::*;

	logic  valid_q;
	half_t c_q;
	half_t d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q <= rotl(c_i, rot_two);
			d_q <= rotl(d_i, rot_two);
		end
	end

	assign v_o = valid_q;
	assign c_o = c_q;
	assign d_o = d_q;

endmodule

// File: sv/dks_out.sv
// Output stage: picks the occupied cell, applies PC2 and holds the result for the receiver.
module dks_out (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     out_stall,
	input  logic [dks_pkg::ROUNDS-1:0]               cell_v,
	input  logic [dks_pkg::ROUNDS-1:0][dks_pkg::HALF_W-1:0] cell_c,
	input  logic [dks_pkg::ROUNDS-1:0][dks_pkg::HALF_W-1:0] cell_d,
	output logic                                     adv,
	output logic                                     out_valid,
	output dks_pkg::rkey_t                           round_key,
	output dks_pkg::ridx_t                           round_index,
	output logic                                     last
);
	import dks_pkg::*;

	logic  valid_q;
	rkey_t key_q;
	ridx_t idx_q;
	logic  last_q;
	half_t sel_c;
	half_t sel_d;
	ridx_t sel_idx;

	// At most one cell is occupied, so an OR of the masked cells is the selection.
	always_comb begin
		sel_c   = '0;
		sel_d   = '0;
		sel_idx = '0;
		for (int r = 0; r < ROUNDS; r++) begin
			sel_c   = sel_c | (cell_c[r] & {HALF_W{cell_v[r]}});
			sel_d   = sel_d | (cell_d[r] & {HALF_W{cell_v[r]}});
			sel_idx = sel_idx | (IDX_W'(r) & {IDX_W{cell_v[r]}});
		end
	end

	assign adv = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= |cell_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_q  <= pc2({sel_d, sel_c});
			idx_q  <= sel_idx;
			last_q <= (sel_idx == IDX_W'(ROUNDS - 1));
		end
	end

	assign out_valid   = valid_q;
	assign round_key   = key_q;
	assign round_index = idx_q;
	assign last        = last_q;

endmodule

// File: sv/des_key_schedule.sv
// Top level of the DES key schedule: a chain of round cells feeding a registered output stage.
//
// A 64-bit key arrives on the input channel (in_valid, in_stall, key). Each accepted
// request yields sixteen round keys on the output channel (out_valid, out_stall,
// round_key, round_index, last), in round order 0 to 15, with last set on round 15.
// The key passes through PC1 and enters the first of sixteen round cells; each cell
// applies its own fixed rotation of one or two places to both halves and hands them on.
// Only one key lives in the chain at a time, and its position is its round number.
// Round 0 is held first in the first cell and then in the output register before it
// appears on the output, and further rounds follow one per cycle while the receiver
// keeps out_stall low. All cells share the single output register, and the chain holds
// one key at a time: a new key is taken on the same edge at which round 15 moves into
// the output register, so consecutive runs follow with no gap.
// When the receiver stalls, the output register holds its round key and the whole
// chain freezes; an empty chain still takes a key while a result waits.
// Reset clears the cell valid bits and the output valid bit, leaving the block idle.
module des_key_schedule (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dks_pkg::KEY_W-1:0]     key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output dks_pkg::rkey_t                round_key,
	output dks_pkg::ridx_t                round_index,
	output logic                          last
);
	import dks_pkg::*;

	logic [ROUNDS-1:0]             cell_v;
	logic [ROUNDS-1:0][HALF_W-1:0] cell_c;
	logic [ROUNDS-1:0][HALF_W-1:0] cell_d;
	logic                          adv;
	logic                          any_v;
	logic                          cell_en;
	logic                          in_fire;
	cd_t                           cd_in;

	assign any_v = |cell_v;

	// The chain moves whenever the output register can take a round key. An empty
	// chain may always load, since only zero valid bits shift through it.
	assign cell_en = adv || !any_v;

	// A new key may enter when the chain is empty, or when the last round is leaving.
	assign in_stall = !(!any_v || (adv && cell_v[ROUNDS-1]));
	assign in_fire  = in_valid && !in_stall;

	assign cd_in = pc1(key);

	// The first cell takes the PC1 halves; every other cell takes its neighbour's.
	for (genvar r = 0; r < ROUNDS; r++) begin : g_cell
		if (r == 0) begin : g_head
			dks_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (cell_en),
				.rot_two (ROT_TWO[r]),
				.v_i     (in_fire),
				.c_i     (cd_in[HALF_W-1:0]),
				.d_i     (cd_in[CD_W-1:HALF_W]),
				.v_o     (cell_v[r]),
				.c_o     (cell_c[r]),
				.d_o     (cell_d[r])
			);
		end else begin : g_body
			dks_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (cell_en),
				.rot_two (ROT_TWO[r]),
				.v_i     (cell_v[r-1]),
				.c_i     (cell_c[r-1]),
				.d_i     (cell_d[r-1]),
				.v_o     (cell_v[r]),
				.c_o     (cell_c[r]),
				.d_o     (cell_d[r])
			);
		end
	end

	dks_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.out_stall   (out_stall),
		.cell_v      (cell_v),
		.cell_c      (cell_c),
		.cell_d      (cell_d),
		.adv         (adv),
		.out_valid   (out_valid),
		.round_key   (round_key),
		.round_index (round_index),
		.last        (last)
	);

	// Only one key may ever be held in the chain.
	a_one_key: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cell_v))
		else $error("more than one round cell occupied");

	// An accepted key must land in the first cell.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> cell_v[0])
		else $error("accepted key did not enter the first cell");

	// When the final cell drains, the output must present the last round.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cell_v[ROUNDS-1]) |=> (out_valid && last))
		else $error("final round did not reach the output");

endmodule
